>>> sv/rlb_pkg.sv
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared constants and the greyscale helper of the logo band decoder.
// ----------------------------------------------------------------------------
package rlb_pkg;

  // default geometry of the logo and of the band
  localparam int LINE_PIXELS_DEF = 224;
  localparam int BAND_ROWS_DEF   = 8;
  localparam int LOGO_ROWS_DEF   = 96;

  // width of the logo pixel position and its saturation value
  localparam int          POS_W   = 17;
  localparam logic [16:0] POS_MAX = 17'h1ffff;

  // result field widths
  localparam int BAND_W   = 11;
  localparam int COLOUR_W = 16;

  // register file
  localparam int         CFG_ADDR_W = 3;
  localparam logic [0:0] REG_BAND_FIRST_ROW = 1'b0;
  localparam logic [0:0] REG_COLOUR_ACTIVE  = 1'b1;

  // greyscale of a byte-swapped rgb565 colour, packed back the same way
  function automatic logic [15:0] to_grey(input logic [15:0] c);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    logic [7:0] sum;
    logic [5:0] avg;
    r   = c[7:3];
    g   = {c[2:0], c[15:13]};
    b   = c[12:8];
    sum = {2'b00, r, 1'b0} + {2'b00, g} + {2'b00, b, 1'b0};
    avg = sum[7:2];
    return {avg[2:0], avg[5:1], avg[5:1], avg[5:3]};
  endfunction

endpackage

>>> sv/rle_logo_band_decoder.sv
// ----------------------------------------------------------------------------
// rle_logo_band_decoder
// Escape-marker run-length decoder that clips decoded runs to one band of
// lines of an rgb565 logo and optionally turns their colour to grey.
// ----------------------------------------------------------------------------
//  channel  direction  transfer                      payload
//  in       sink       in_valid & !in_stall          code word, stream start
//  out      source     out_valid & !out_stall        band position, length,
//                                                    colour, band full
//  cfg      apb slave  psel & penable & pwrite       band first row, colour on
//
// One code word is taken every cycle. The decode, position update and band
// clipping all happen in the cycle a word is accepted; a resulting run lands
// in the output register and is offered the next cycle. Input stalls only
// while a held run is itself stalled at the output.
// Synchronous active-low reset clears decode state, the output valid and
// the registers to row zero with colour on.
module rle_logo_band_decoder
  import rlb_pkg::*;
#(
  parameter int LINE_PIXELS = LINE_PIXELS_DEF,
  parameter int BAND_ROWS   = BAND_ROWS_DEF,
  parameter int LOGO_ROWS   = LOGO_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_code_word,
  input  logic                  in_stream_start,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BAND_W-1:0]     out_band_position,
  output logic [BAND_W-1:0]     out_run_pixels,
  output logic [COLOUR_W-1:0]   out_pixel_colour,
  output logic                  out_band_full,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // signed working width: covers row*line, band end and unsaturated run end
  localparam int ROWS_SPAN = (LOGO_ROWS > 128) ? LOGO_ROWS : 128;
  localparam int SW = $clog2((ROWS_SPAN + BAND_ROWS + 1) * LINE_PIXELS
                             + 2 ** (POS_W + 1)) + 2;

  localparam logic signed [SW-1:0] LINE_S = SW'(LINE_PIXELS);
  localparam logic signed [SW-1:0] BAND_S = SW'(BAND_ROWS);
  localparam logic signed [SW-1:0] LOGO_S = SW'(LOGO_ROWS);
  localparam logic signed [SW-1:0] PMAX_S = SW'(POS_MAX);

  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_COUNT,
    PH_COLOUR
  } phase_t;

  // configuration registers
  logic signed [7:0] band_first_row_r;
  logic              colour_active_r;

  // decode state
  phase_t            phase_r, phase_nxt;
  logic [15:0]       marker_r, marker_nxt;
  logic [15:0]       count_r, count_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              done_r, done_nxt;

  // output register
  logic                out_valid_r;
  logic [BAND_W-1:0]   band_position_r;
  logic [BAND_W-1:0]   run_pixels_r;
  logic [COLOUR_W-1:0] pixel_colour_r;
  logic                band_full_r;

  logic in_accept;
  logic cfg_write;

  // band geometry from the row register
  logic signed [SW-1:0] row_s;
  logic signed [SW-1:0] row_end_s;
  logic signed [SW-1:0] bend_row_s;
  logic signed [SW-1:0] bstart_s;
  logic signed [SW-1:0] bend_s;
  logic                 band_ok;

  // run clipping
  logic                 is_run;
  logic [POS_W-1:0]     run_len;
  logic signed [SW-1:0] start_s;
  logic signed [SW-1:0] end_s;
  logic signed [SW-1:0] lo_s;
  logic signed [SW-1:0] hi_s;
  logic signed [SW-1:0] offs_s;
  logic signed [SW-1:0] len_s;
  logic                 hit;
  logic                 reach_end;
  logic [15:0]          colour_sel;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_BAND_FIRST_ROW: prdata = {24'd0, band_first_row_r};
      REG_COLOUR_ACTIVE:  prdata = {31'd0, colour_active_r};
      default:            prdata = 32'd0;
    endcase
  end

  // band limits in logo pixels
  always_comb begin
    row_s      = SW'(band_first_row_r);
    row_end_s  = row_s + BAND_S;
    bend_row_s = (row_end_s > LOGO_S) ? LOGO_S : row_end_s;
    bstart_s   = row_s * LINE_S;
    bend_s     = bend_row_s * LINE_S;
    band_ok    = row_s < LOGO_S;
  end

  // decode one word and clip the run it closes
  always_comb begin
    phase_nxt  = phase_r;
    marker_nxt = marker_r;
    count_nxt  = count_r;
    done_nxt   = done_r;
    is_run     = 1'b0;
    run_len    = POS_W'(1);

    if (in_stream_start) begin
      marker_nxt = in_code_word;
      phase_nxt  = PH_PLAIN;
      count_nxt  = 16'd0;
    end else if (!done_r) begin
      unique case (phase_r)
        PH_COUNT: begin
          count_nxt = in_code_word;
          phase_nxt = PH_COLOUR;
        end
        PH_COLOUR: begin
          phase_nxt = PH_PLAIN;
          is_run    = 1'b1;
          run_len   = {1'b0, count_r} + POS_W'(1);
        end
        default: begin
          if (in_code_word == marker_r) begin
            phase_nxt = PH_COUNT;
          end else begin
            is_run = 1'b1;
          end
        end
      endcase
    end

    start_s   = signed'(SW'(pos_r));
    end_s     = start_s + signed'(SW'(run_len));
    lo_s      = (start_s > bstart_s) ? start_s : bstart_s;
    hi_s      = (end_s < bend_s) ? end_s : bend_s;
    offs_s    = lo_s - bstart_s;
    len_s     = hi_s - lo_s;
    hit       = is_run & band_ok & (hi_s > lo_s);
    reach_end = hi_s == bend_s;

    // position moves on every run, saturating
    if (in_stream_start) begin
      pos_nxt = '0;
    end else if (is_run) begin
      pos_nxt = (end_s > PMAX_S) ? POS_MAX : end_s[POS_W-1:0];
    end else begin
      pos_nxt = pos_r;
    end

    if (in_stream_start) begin
      done_nxt = 1'b0;
    end else if (hit && reach_end) begin
      done_nxt = 1'b1;
    end

    colour_sel = colour_active_r ? in_code_word : to_grey(in_code_word);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_first_row_r <= 8'sd0;
      colour_active_r  <= 1'b1;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_BAND_FIRST_ROW: band_first_row_r <= signed'(pwdata[7:0]);
        REG_COLOUR_ACTIVE:  colour_active_r  <= pwdata[0];
        default:            ;
      endcase
    end
  end

  // decode state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_PLAIN;
      marker_r        <= 16'd0;
      count_r         <= 16'd0;
      pos_r           <= '0;
      done_r          <= 1'b0;
      out_valid_r     <= 1'b0;
      band_position_r <= '0;
      run_pixels_r    <= '0;
      pixel_colour_r  <= '0;
      band_full_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r  <= phase_nxt;
        marker_r <= marker_nxt;
        count_r  <= count_nxt;
        pos_r    <= pos_nxt;
        done_r   <= done_nxt;
      end
      if (in_accept && hit) begin
        out_valid_r     <= 1'b1;
        band_position_r <= offs_s[BAND_W-1:0];
        run_pixels_r    <= len_s[BAND_W-1:0];
        pixel_colour_r  <= colour_sel;
        band_full_r     <= reach_end;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_band_position = band_position_r;
  assign out_run_pixels    = run_pixels_r;
  assign out_pixel_colour  = pixel_colour_r;
  assign out_band_full     = band_full_r;

endmodule

>>> sim/rle_logo_band_decoder_tb.sv
// ----------------------------------------------------------------------------
// rle_logo_band_decoder_tb
// Self-checking bench for the escape-marker logo band decoder. A directed
// table covers the stream-start, escape, band-full, greyscale and
// empty-band corners. Random streams then run under changing band rows and
// colour modes. Every accepted code word goes through a local decoder model,
// and each run transfer at the output is compared field by field, in order.
// ----------------------------------------------------------------------------
module rle_logo_band_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlb_pkg::*;

  localparam int RANDOM_WORDS   = 1600;
  localparam int CALM_WORDS     = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 3;

  typedef enum logic [1:0] {DEC_PLAIN, DEC_COUNT, DEC_COLOUR} dec_phase_t;

  typedef struct packed {
    logic [BAND_W-1:0]   band_pos;
    logic [BAND_W-1:0]   pixels;
    logic [COLOUR_W-1:0] colour;
    logic                full;
  } band_run_t;

  typedef struct {
    bit          is_reg;
    logic [0:0]  reg_idx;
    logic [31:0] value;
    logic [15:0] word;
    logic        start;
    bit          typed;
    bit          hit;
    band_run_t   run;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [15:0]           in_code_word;
  logic                  in_stream_start;
  logic                  out_valid;
  logic                  out_stall;
  logic [BAND_W-1:0]     out_band_position;
  logic [BAND_W-1:0]     out_run_pixels;
  logic [COLOUR_W-1:0]   out_pixel_colour;
  logic                  out_band_full;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // decoder model state and its copy of the registers
  logic [15:0]       esc_marker;
  dec_phase_t        dec_phase;
  logic [15:0]       pending_len;
  logic [POS_W-1:0]  logo_pos;
  logic              band_filled;
  logic signed [7:0] first_row_cfg;
  logic              colour_on_cfg;

  band_run_t runs_due[$];
  stim_row_t directed_rows[$];
  bit        failed;
  bit        calm_tail;
  int        idle_cycles;
  int        stall_left;
  bit        stall_now;

  rle_logo_band_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_code_word      (in_code_word),
    .in_stream_start   (in_stream_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_band_position (out_band_position),
    .out_run_pixels    (out_run_pixels),
    .out_pixel_colour  (out_pixel_colour),
    .out_band_full     (out_band_full),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // grey level of a byte-swapped rgb565 colour, packed back the same way
  function automatic logic [15:0] grey_of_rgb565(input logic [15:0] c);
    int cv, red, green, blue, level;
    cv    = int'(c);
    red   = (cv >> 3) & 31;
    green = ((cv << 3) & 'h38) | ((cv >> 13) & 7);
    blue  = (cv >> 8) & 31;
    level = (2 * red + green + 2 * blue) / 4;
    return 16'(((level << 13) & 'he000) | ((level << 7) & 'h1f00) |
               ((level << 2) & 'h00f8) | ((level >> 3) & 'h0007));
  endfunction

  // advance the logo position by one run and clip it to the band
  function automatic bit clip_run(input int len, input logic [15:0] colour,
                                  output band_run_t run);
    int row, first, last, band_len, bstart, bend, lo, hi;
    row   = int'(first_row_cfg);
    first = int'(logo_pos);
    last  = first + len;
    run   = '0;
    logo_pos = (last > int'(POS_MAX)) ? POS_MAX : POS_W'(last);
    if (row <= LOGO_ROWS_DEF - BAND_ROWS_DEF) begin
      band_len = BAND_ROWS_DEF * LINE_PIXELS_DEF;
    end else if (row < LOGO_ROWS_DEF) begin
      band_len = (LOGO_ROWS_DEF - row) * LINE_PIXELS_DEF;
    end else begin
      band_len = 0;
    end
    if (band_len <= 0) return 1'b0;
    bstart = row * LINE_PIXELS_DEF;
    bend   = bstart + band_len;
    lo     = (first > bstart) ? first : bstart;
    hi     = (last < bend) ? last : bend;
    if (hi <= lo) return 1'b0;
    if (hi == bend) band_filled = 1'b1;
    run.band_pos = BAND_W'(lo - bstart);
    run.pixels   = BAND_W'(hi - lo);
    run.colour   = colour_on_cfg ? colour : grey_of_rgb565(colour);
    run.full     = (hi == bend);
    return 1'b1;
  endfunction

  // one code word through the escape decoder; 1 when a run comes out
  function automatic bit decode_word(input logic [15:0] w, input logic st,
                                     output band_run_t run);
    run = '0;
    if (st) begin
      esc_marker  = w;
      dec_phase   = DEC_PLAIN;
      pending_len = '0;
      logo_pos    = '0;
      band_filled = 1'b0;
      return 1'b0;
    end
    if (band_filled) return 1'b0;
    case (dec_phase)
      DEC_COUNT: begin
        pending_len = w;
        dec_phase   = DEC_COLOUR;
        return 1'b0;
      end
      DEC_COLOUR: begin
        dec_phase = DEC_PLAIN;
        return clip_run(int'(pending_len) + 1, w, run);
      end
      default: begin
        if (w == esc_marker) begin
          dec_phase = DEC_COUNT;
          return 1'b0;
        end
        return clip_run(1, w, run);
      end
    endcase
  endfunction

  function automatic void add_none(input logic [15:0] w, input logic st);
    stim_row_t r;
    r = '{default: '0};
    r.word  = w;
    r.start = st;
    r.typed = 1'b1;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_run(input logic [15:0] w, input int pos, input int len,
                                  input logic [15:0] colour, input logic full);
    stim_row_t r;
    r = '{default: '0};
    r.word  = w;
    r.typed = 1'b1;
    r.hit   = 1'b1;
    r.run   = '{band_pos: BAND_W'(pos), pixels: BAND_W'(len), colour: colour, full: full};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_reg(input logic [0:0] idx, input logic [31:0] value);
    stim_row_t r;
    r = '{default: '0};
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.value   = value;
    directed_rows.push_back(r);
  endfunction

  // offer one code word, wait for its transfer, then maybe idle a while
  task automatic send_word(input logic [15:0] w, input logic st, input bit typed,
                           input bit typed_hit, input band_run_t typed_run);
    band_run_t run;
    bit        hit;
    in_code_word    <= w;
    in_stream_start <= st;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    hit = decode_word(w, st, run);
    if (typed) begin
      hit = typed_hit;
      run = typed_run;
    end
    if (hit) runs_due.push_back(run);
    if (!calm_tail && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // register write once every run has left the block
  task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
    in_valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BAND_FIRST_ROW) first_row_cfg = value[7:0];
    else colour_on_cfg = value[0];
  endtask

  // result side: random stall bursts, none in the calm tail
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_now  = ($urandom_range(0, 3) == 0);
      stall_left = stall_now ? $urandom_range(1, 12) : $urandom_range(1, 40);
    end
    stall_left--;
    out_stall <= stall_now && !calm_tail;
  end

  // run transfer check and watchdog
  always @(posedge clk) begin
    band_run_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (runs_due.size() == 0) begin
          $error("unexpected run: band_position %0d run_pixels %0d pixel_colour %h",
                 out_band_position, out_run_pixels, out_pixel_colour);
          failed = 1'b1;
        end else begin
          want = runs_due.pop_front();
          if (out_band_position !== want.band_pos) begin
            $error("band_position: expected %0d, got %0d", want.band_pos, out_band_position);
            failed = 1'b1;
          end
          if (out_run_pixels !== want.pixels) begin
            $error("run_pixels: expected %0d, got %0d", want.pixels, out_run_pixels);
            failed = 1'b1;
          end
          if (out_pixel_colour !== want.colour) begin
            $error("pixel_colour: expected %h, got %h", want.colour, out_pixel_colour);
            failed = 1'b1;
          end
          if (out_band_full !== want.full) begin
            $error("band_full: expected %0d, got %0d", want.full, out_band_full);
            failed = 1'b1;
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** rle_logo_band_decoder: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int        words_done;
    int        phase_len;
    int        phase_cnt;
    int        row;
    int        roll;
    bit        wide_runs;
    logic [15:0] w;
    logic      st;
    band_run_t no_run;

    no_run          = '0;
    failed          = 1'b0;
    calm_tail       = 1'b0;
    idle_cycles     = 0;
    stall_left      = 0;
    stall_now       = 1'b0;
    esc_marker      = '0;
    dec_phase       = DEC_PLAIN;
    pending_len     = '0;
    logo_pos        = '0;
    band_filled     = 1'b0;
    first_row_cfg   = '0;
    colour_on_cfg   = 1'b1;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_code_word    <= '0;
    in_stream_start <= 1'b0;
    out_stall       <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;

    // directed table, registers at reset: row zero, colour on
    add_run(16'h1234, 0, 1, 16'h1234, 1'b0);       // no stream start yet, marker 0
    add_none(16'hffff, 1'b1);                      // marker of all ones
    add_run(16'h0000, 0, 1, 16'h0000, 1'b0);
    add_none(16'hffff, 1'b0);                      // escape
    add_none(16'hffff, 1'b0);                      // largest count
    add_run(16'habcd, 1, 1791, 16'habcd, 1'b1);    // fills the band
    add_none(16'h5555, 1'b0);                      // ignored once full
    add_none(16'h0000, 1'b1);                      // restart while full
    add_none(16'h0000, 1'b0);
    add_none(16'h06fe, 1'b0);
    add_run(16'h8001, 0, 1791, 16'h8001, 1'b0);
    add_run(16'h7ffe, 1791, 1, 16'h7ffe, 1'b1);    // last band pixel
    add_reg(REG_COLOUR_ACTIVE, 32'd0);
    add_none(16'h1111, 1'b1);
    add_run(16'hffff, 0, 1, 16'hd7bd, 1'b0);       // white to grey
    add_run(16'h0000, 1, 1, 16'h0000, 1'b0);
    add_reg(REG_BAND_FIRST_ROW, 32'hffff_fff9);    // lowest row whose band still reaches the logo
    add_none(16'h2222, 1'b1);
    add_none(16'h2222, 1'b0);
    add_none(16'h0001, 1'b0);
    add_run(16'h0000, 1568, 2, 16'h0000, 1'b0);
    add_reg(REG_BAND_FIRST_ROW, 32'd95);           // band cut by the logo end
    add_reg(REG_COLOUR_ACTIVE, 32'd1);
    add_none(16'h3333, 1'b1);
    add_none(16'h3333, 1'b0);
    add_none(16'hffff, 1'b0);
    add_run(16'h1234, 0, 224, 16'h1234, 1'b1);
    add_reg(REG_BAND_FIRST_ROW, 32'd96);           // empty band
    add_none(16'haaaa, 1'b1);
    add_none(16'h0001, 1'b0);
    add_reg(REG_BAND_FIRST_ROW, 32'hffff_fff8);    // band wholly above the logo
    add_none(16'h0001, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        reg_write(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_word(directed_rows[i].word, directed_rows[i].start, 1'b1,
                  directed_rows[i].hit, directed_rows[i].run);
      end
    end

    // random streams, one register setting per phase
    words_done = 0;
    while (words_done < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        row = -7;
      end else if (roll < 20) begin
        row = 95;
      end else if (roll < 30) begin
        row = $urandom_range(0, 1) ? $urandom_range(96, 127) : -$urandom_range(8, 128);
      end else begin
        row = $urandom_range(0, 102) - 7;
      end
      wide_runs = (row >= LOGO_ROWS_DEF) || (row <= -BAND_ROWS_DEF);
      reg_write(REG_BAND_FIRST_ROW, 32'(row));
      reg_write(REG_COLOUR_ACTIVE, 32'($urandom_range(0, 1)));
      phase_len = $urandom_range(40, 160);
      phase_cnt = 0;
      while (phase_cnt < phase_len && words_done < RANDOM_WORDS) begin
        calm_tail = (words_done >= RANDOM_WORDS - CALM_WORDS);
        roll = $urandom_range(0, 99);
        st   = 1'b0;
        w    = 16'($urandom_range(0, 65535));
        if ((phase_cnt == 0 && roll < 90) || (band_filled && roll < 85) || roll < 3) begin
          st = 1'b1;
          if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        end else if (!band_filled && roll >= 7) begin
          // well-formed content for the current decode phase
          case (dec_phase)
            DEC_PLAIN: begin
              if ($urandom_range(0, 99) < 40) w = esc_marker;
            end
            DEC_COUNT: begin
              roll = $urandom_range(0, 99);
              if (wide_runs && roll < 50) w = 16'($urandom_range(0, 65535));
              else if (roll < 50) w = 16'($urandom_range(0, 63));
              else if (roll < 80) w = 16'($urandom_range(0, 1023));
              else if (roll < 95) w = 16'($urandom_range(0, 8191));
            end
            default: ;
          endcase
        end
        // words dropped after the band is full do not count
        if (st || !band_filled) begin
          words_done++;
          phase_cnt++;
        end
        send_word(w, st, 1'b0, 1'b0, no_run);
      end
    end

    in_valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + 2) @(posedge clk);
    if (!failed) begin
      $display("** rle_logo_band_decoder: PASSED **");
    end else begin
      $display("** rle_logo_band_decoder: FAILED **");
    end
    $finish;
  end

endmodule
